// ===== hdl/ray_triangle_intersect_defines.svh =====
// Assertion macros for the ray/triangle intersection block
`ifndef RAY_TRIANGLE_INTERSECT_DEFINES_SVH
`define RAY_TRIANGLE_INTERSECT_DEFINES_SVH
// implication checked every cycle outside reset
`define RTI_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("rti check failed");
// next-cycle implication checked outside reset
`define RTI_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("rti check failed");
`endif

// ===== hdl/rti_pkg.sv =====
// Shared types and widths for the ray/triangle intersection block
package rti_pkg;
  localparam int COORD_BITS_DEF = 21;
  localparam int FRAC_BITS      = 10;
  localparam int REG_BITS       = 63;
  localparam int MAT_BITS       = 8;
  localparam int CFG_IDX_BITS   = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_VERTEX_ZERO = 3'd0,
    CFG_EDGE_ONE    = 3'd1,
    CFG_EDGE_TWO    = 3'd2,
    CFG_NORMAL      = 3'd3,
    CFG_MATERIAL    = 3'd4
  } cfg_idx_t;
endpackage

// ===== hdl/ray_triangle_intersect.sv =====
// Top level of the ray/triangle intersection pipeline
// Usage:
//   Input words on in_tdata carry one ray each: origin, direction and an open
//   t interval. The triangle, its unit normal and material tag are set through
//   the cfg_ write port while no ray is in flight.
//   Every input word gives exactly one output word: hit flag, t, hit point,
//   normal turned toward the ray, front-face flag and material; all fields
//   are zero on a miss.
//   Throughput is one ray per cycle while the output is not stalled. The pipe
//   is five geometry stages, one quotient bit per divider stage (COORD_BITS +
//   2) and three shading stages, the last of which is the output register.
//   The whole pipe advances as one; when out_tready is low and the output
//   register is full, the pipe holds and in_tready drops, so nothing is lost
//   or repeated.
//   Reset (rst_n low, synchronous) clears all valid bits and the
//   configuration registers to zero.
module ray_triangle_intersect
  import rti_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_lower, t_upper
  input  logic [((8*COORD_BITS+7)/8)*8-1:0]   in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // hit, hit_t, point_x, point_y, point_z, facing_nx, facing_ny, facing_nz,
  // front_face, hit_material
  output logic [((7*COORD_BITS+10+7)/8)*8-1:0] out_tdata,
  input  logic                                cfg_we,
  input  logic [rti_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [rti_pkg::REG_BITS-1:0]        cfg_wdata
);
  localparam int CW   = COORD_BITS;
  localparam int DW   = 3*CW + 4;
  localparam int QB   = CW + 2;
  localparam int LAT  = 5 + QB + 3;
  localparam int RD   = 5 + QB;
  localparam int IW   = ((8*CW+7)/8)*8;
  localparam int OW   = ((7*CW+10+7)/8)*8;
  localparam int SIDE = 2;

  logic [REG_BITS-1:0] v0_r, e1_r, e2_r, nrm_r;
  logic [MAT_BITS-1:0] mat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r  <= '0;
      e1_r  <= '0;
      e2_r  <= '0;
      nrm_r <= '0;
      mat_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VERTEX_ZERO: v0_r  <= cfg_wdata;
        CFG_EDGE_ONE:    e1_r  <= cfg_wdata;
        CFG_EDGE_TWO:    e2_r  <= cfg_wdata;
        CFG_NORMAL:      nrm_r <= cfg_wdata;
        CFG_MATERIAL:    mat_r <= cfg_wdata[MAT_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic signed [CW-1:0] o [3], d [3], v0 [3], e1 [3], e2 [3], n [3];
  logic signed [CW-1:0] lo, hi;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      o[k]  = in_tdata[k*CW +: CW];
      d[k]  = in_tdata[(3+k)*CW +: CW];
      v0[k] = v0_r[k*CW +: CW];
      e1[k] = e1_r[k*CW +: CW];
      e2[k] = e2_r[k*CW +: CW];
      n[k]  = nrm_r[k*CW +: CW];
    end
    lo = in_tdata[6*CW +: CW];
    hi = in_tdata[7*CW +: CW];
  end

  // global enable: advance when output register is free or being drained
  logic en;
  logic out_v_r;
  assign en        = !out_v_r || out_tready;
  assign in_tready = en;

  // valid bits and raw ray fields carried alongside the arithmetic
  logic                 vld_r [LAT];
  logic [IW-1:0]        ray_r [RD];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_tvalid;
      for (int i = 1; i < LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ray_r[0] <= in_tdata;
      for (int i = 1; i < RD; i++) ray_r[i] <= ray_r[i-1];
    end
  end

  logic          g_pass, g_tneg;
  logic [DW-1:0] g_tmag, g_det;
  rti_geometry #(.COORD_BITS(CW)) u_geo (
    .clk(clk), .en(en), .o(o), .d(d), .v0(v0), .e1(e1), .e2(e2),
    .pass(g_pass), .tmag(g_tmag), .tneg(g_tneg), .det_o(g_det)
  );

  logic [QB-1:0]   quo;
  logic [SIDE-1:0] side_o;
  rti_divider #(.NUM_BITS(DW + FRAC_BITS), .DEN_BITS(DW), .Q_BITS(QB),
                .SIDE_BITS(SIDE)) u_div (
    .clk(clk), .en(en),
    .num((DW + FRAC_BITS)'(g_tmag) << FRAC_BITS),
    .den(g_det), .side_in({g_tneg, g_pass}),
    .quo(quo), .side_out(side_o)
  );

  // ray fields aligned with divider output
  logic [IW-1:0]        ray_d;
  logic signed [CW-1:0] od [3], dd [3];
  logic signed [CW-1:0] lod, hid;
  assign ray_d = ray_r[RD-1];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      od[k] = ray_d[k*CW +: CW];
      dd[k] = ray_d[(3+k)*CW +: CW];
    end
    lod = ray_d[6*CW +: CW];
    hid = ray_d[7*CW +: CW];
  end

  logic                 s_hit, s_front;
  logic signed [CW-1:0] s_t;
  logic signed [CW-1:0] s_pt [3], s_fn [3];
  rti_shade #(.COORD_BITS(CW)) u_shd (
    .clk(clk), .en(en), .pass(side_o[0]), .tneg(side_o[1]), .quo(quo),
    .o(od), .d(dd), .n(n), .lo(lod), .hi(hid),
    .hit(s_hit), .t_o(s_t), .pt(s_pt), .fn(s_fn), .front(s_front)
  );

  assign out_v_r    = vld_r[LAT-1];
  assign out_tvalid = out_v_r;
  assign out_tdata  = OW'({s_hit ? mat_r : {MAT_BITS{1'b0}}, s_front,
                           s_fn[2], s_fn[1], s_fn[0],
                           s_pt[2], s_pt[1], s_pt[0], s_t, s_hit});
endmodule

// ===== hdl/rti_divider.sv =====
// Pipelined restoring divider: quotient = floor(num / den), one bit per stage
module rti_divider #(
  parameter int NUM_BITS = 64,
  parameter int DEN_BITS = 64,
  parameter int Q_BITS   = 22,
  parameter int SIDE_BITS = 8
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [NUM_BITS-1:0]  num,
  input  logic [DEN_BITS-1:0]  den,
  input  logic [SIDE_BITS-1:0] side_in,
  output logic [Q_BITS-1:0]    quo,
  output logic [SIDE_BITS-1:0] side_out
);
  // each stage decides quotient bit Q_BITS-1-i against den << (Q_BITS-1-i)
  localparam int RW = NUM_BITS + 1;
  logic [RW-1:0]        rem_r  [Q_BITS+1];
  logic [DEN_BITS-1:0]  den_r  [Q_BITS+1];
  logic [Q_BITS-1:0]    q_r    [Q_BITS+1];
  logic [SIDE_BITS-1:0] side_r [Q_BITS+1];

  always_comb begin
    rem_r[0]  = RW'(num);
    den_r[0]  = den;
    q_r[0]    = '0;
    side_r[0] = side_in;
  end

  for (genvar i = 0; i < Q_BITS; i++) begin : g_stage
    localparam int SH = Q_BITS - 1 - i;
    logic [RW+Q_BITS-1:0] dsh;
    logic                 ge;
    assign dsh = (RW+Q_BITS)'(den_r[i]) << SH;
    assign ge  = (RW+Q_BITS)'(rem_r[i]) >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1]  <= ge ? RW'((RW+Q_BITS)'(rem_r[i]) - dsh) : rem_r[i];
        den_r[i+1]  <= den_r[i];
        q_r[i+1]    <= {q_r[i][Q_BITS-2:0], ge};
        side_r[i+1] <= side_r[i];
      end
    end
  end

  assign quo      = q_r[Q_BITS];
  assign side_out = side_r[Q_BITS];
endmodule

// ===== hdl/rti_geometry.sv =====
// Front stages: cross products, dot products, sign fold and barycentric test
module rti_geometry
  import rti_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [COORD_BITS-1:0] o   [3],
  input  logic signed [COORD_BITS-1:0] d   [3],
  input  logic signed [COORD_BITS-1:0] v0  [3],
  input  logic signed [COORD_BITS-1:0] e1  [3],
  input  logic signed [COORD_BITS-1:0] e2  [3],
  output logic                         pass,
  output logic [3*COORD_BITS+3:0]      tmag,
  output logic                         tneg,
  output logic [3*COORD_BITS+3:0]      det_o
);
  localparam int CW = COORD_BITS;
  localparam int SW = CW + 1;
  localparam int PW = 2*CW + 2;
  localparam int HW = PW - FRAC_BITS;
  localparam int DW = 3*CW + 4;

  // stage 1: s = o - v0, products for h and q
  logic signed [SW-1:0] s_c [3];
  logic signed [PW-1:0] hp_r [6];
  logic signed [PW-1:0] qp_r [6];
  logic signed [CW-1:0] d1_r [3];
  logic signed [CW-1:0] e1a_r [3];
  logic signed [CW-1:0] e2a_r [3];
  logic signed [SW-1:0] s1_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) s_c[k] = SW'(o[k]) - SW'(v0[k]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hp_r[0] <= PW'(d[1]) * PW'(e2[2]);
      hp_r[1] <= PW'(d[2]) * PW'(e2[1]);
      hp_r[2] <= PW'(d[2]) * PW'(e2[0]);
      hp_r[3] <= PW'(d[0]) * PW'(e2[2]);
      hp_r[4] <= PW'(d[0]) * PW'(e2[1]);
      hp_r[5] <= PW'(d[1]) * PW'(e2[0]);
      qp_r[0] <= PW'(s_c[1]) * PW'(e1[2]);
      qp_r[1] <= PW'(s_c[2]) * PW'(e1[1]);
      qp_r[2] <= PW'(s_c[2]) * PW'(e1[0]);
      qp_r[3] <= PW'(s_c[0]) * PW'(e1[2]);
      qp_r[4] <= PW'(s_c[0]) * PW'(e1[1]);
      qp_r[5] <= PW'(s_c[1]) * PW'(e1[0]);
      d1_r  <= d;
      e1a_r <= e1;
      e2a_r <= e2;
      s1_r  <= s_c;
    end
  end

  // stage 2: differences and floor shift (arithmetic shift is floor)
  logic signed [PW-1:0] hd_c [3];
  logic signed [PW-1:0] qd_c [3];
  logic signed [HW-1:0] h_r [3];
  logic signed [HW-1:0] q_r [3];
  logic signed [CW-1:0] d2_r [3];
  logic signed [CW-1:0] e1b_r [3];
  logic signed [CW-1:0] e2b_r [3];
  logic signed [SW-1:0] s2_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hd_c[k] = hp_r[2*k] - hp_r[2*k+1];
      qd_c[k] = qp_r[2*k] - qp_r[2*k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        h_r[k] <= HW'(hd_c[k] >>> FRAC_BITS);
        q_r[k] <= HW'(qd_c[k] >>> FRAC_BITS);
      end
      d2_r  <= d1_r;
      e1b_r <= e1a_r;
      e2b_r <= e2a_r;
      s2_r  <= s1_r;
    end
  end

  // stage 3: dot-product terms
  logic signed [DW-1:0] dt_r [3];
  logic signed [DW-1:0] ut_r [3];
  logic signed [DW-1:0] vt_r [3];
  logic signed [DW-1:0] tt_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        dt_r[k] <= DW'(e1b_r[k]) * DW'(h_r[k]);
        ut_r[k] <= DW'(s2_r[k]) * DW'(h_r[k]);
        vt_r[k] <= DW'(d2_r[k]) * DW'(q_r[k]);
        tt_r[k] <= DW'(e2b_r[k]) * DW'(q_r[k]);
      end
    end
  end

  // stage 4: sums
  logic signed [DW-1:0] det_r, un_r, vn_r, tn_r;
  always_ff @(posedge clk) begin
    if (en) begin
      det_r <= dt_r[0] + dt_r[1] + dt_r[2];
      un_r  <= ut_r[0] + ut_r[1] + ut_r[2];
      vn_r  <= vt_r[0] + vt_r[1] + vt_r[2];
      tn_r  <= tt_r[0] + tt_r[1] + tt_r[2];
    end
  end

  // stage 5: fold sign of det, range tests
  logic                 dneg;
  logic signed [DW-1:0] det_c, un_c, vn_c, tn_c;
  logic                 ok_c;
  always_comb begin
    dneg  = det_r < 0;
    det_c = dneg ? -det_r : det_r;
    un_c  = dneg ? -un_r  : un_r;
    vn_c  = dneg ? -vn_r  : vn_r;
    tn_c  = dneg ? -tn_r  : tn_r;
    ok_c  = (det_r != '0) && (un_c >= 0) && (un_c <= det_c) && (vn_c >= 0)
            && ((DW+1)'(un_c) + (DW+1)'(vn_c) <= (DW+1)'(det_c));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pass  <= ok_c;
      tneg  <= tn_c < 0;
      tmag  <= (tn_c < 0) ? DW'(-tn_c) : DW'(tn_c);
      det_o <= DW'(det_c);
    end
  end
endmodule

// ===== hdl/rti_shade.sv =====
// Back stages: t saturation and interval test, hit point, facing normal
module rti_shade
  import rti_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic                         pass,
  input  logic                         tneg,
  input  logic [COORD_BITS+1:0]        quo,
  input  logic signed [COORD_BITS-1:0] o   [3],
  input  logic signed [COORD_BITS-1:0] d   [3],
  input  logic signed [COORD_BITS-1:0] n   [3],
  input  logic signed [COORD_BITS-1:0] lo,
  input  logic signed [COORD_BITS-1:0] hi,
  output logic                         hit,
  output logic signed [COORD_BITS-1:0] t_o,
  output logic signed [COORD_BITS-1:0] pt  [3],
  output logic signed [COORD_BITS-1:0] fn  [3],
  output logic                         front
);
  localparam int CW = COORD_BITS;
  localparam int PW = 2*CW;
  localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW+1:0] LIM = (CW+2)'(1) << (CW-1);

  // stage A: signed t with saturation, interval check, normal dot product
  logic signed [CW-1:0] t_c;
  logic signed [PW+1:0] dn_c;
  always_comb begin
    if (quo >= LIM) t_c = tneg ? MINV : MAXV;
    else t_c = tneg ? -CW'(quo) : CW'(quo);
    dn_c = (PW+2)'(d[0]) * (PW+2)'(n[0]) + (PW+2)'(d[1]) * (PW+2)'(n[1])
         + (PW+2)'(d[2]) * (PW+2)'(n[2]);
  end

  logic                 ha_r, fa_r;
  logic signed [CW-1:0] ta_r;
  logic signed [CW-1:0] oa_r [3];
  logic signed [CW-1:0] da_r [3];
  logic signed [CW-1:0] na_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      ha_r <= pass && (lo < t_c) && (t_c < hi);
      ta_r <= t_c;
      fa_r <= dn_c < 0;
      oa_r <= o;
      da_r <= d;
      na_r <= n;
    end
  end

  // stage B: t * dir
  logic signed [PW-1:0] pr_r [3];
  logic                 hb_r, fb_r;
  logic signed [CW-1:0] tb_r;
  logic signed [CW-1:0] ob_r [3];
  logic signed [CW-1:0] nb_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) pr_r[k] <= PW'(ta_r) * PW'(da_r[k]);
      hb_r <= ha_r;
      fb_r <= fa_r;
      tb_r <= ta_r;
      ob_r <= oa_r;
      nb_r <= na_r;
    end
  end

  // stage C: point saturate, normal flip, zero on miss
  logic signed [PW:0]   ps_c [3];
  logic signed [CW-1:0] pc   [3];
  logic signed [CW-1:0] fc   [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ps_c[k] = (PW+1)'(ob_r[k]) + (PW+1)'(pr_r[k] >>> FRAC_BITS);
      if (ps_c[k] > (PW+1)'(MAXV)) pc[k] = MAXV;
      else if (ps_c[k] < (PW+1)'(MINV)) pc[k] = MINV;
      else pc[k] = CW'(ps_c[k]);
      if (fb_r) fc[k] = nb_r[k];
      else if (nb_r[k] == MINV) fc[k] = MAXV;
      else fc[k] = -nb_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit   <= hb_r;
      t_o   <= hb_r ? tb_r : '0;
      front <= hb_r && fb_r;
      for (int k = 0; k < 3; k++) begin
        pt[k] <= hb_r ? pc[k] : '0;
        fn[k] <= hb_r ? fc[k] : '0;
      end
    end
  end
endmodule

// ===== hdl/rti_checker.sv =====
// Port-level assertions for the ray/triangle intersection block
`include "ray_triangle_intersect_defines.svh"
module rti_checker #(
  parameter int IW = 168,
  parameter int OW = 160
) (
  input logic          clk,
  input logic          rst_n,
  input logic          in_tvalid,
  input logic          in_tready,
  input logic [IW-1:0] in_tdata,
  input logic          out_tvalid,
  input logic          out_tready,
  input logic [OW-1:0] out_tdata
);
  `RTI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `RTI_ASSERT_IMPLY(a_ready_free, clk, rst_n, !out_tvalid, in_tready)
  `RTI_ASSERT_IMPLY(a_miss_zero, clk, rst_n, out_tvalid && !out_tdata[0], out_tdata == '0)
  `RTI_ASSERT_IMPLY(a_stall_ready, clk, rst_n, out_tvalid && !out_tready, !in_tready)
  `RTI_ASSERT_IMPLY(a_in_known, clk, rst_n, in_tvalid && in_tready, !$isunknown(in_tdata))
endmodule

bind ray_triangle_intersect rti_checker #(
  .IW(((8*COORD_BITS+7)/8)*8), .OW(((7*COORD_BITS+10+7)/8)*8)
) u_rti_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .in_tdata(in_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata)
);
